/* hw/rtl/tldm_pkg.sv */
// Package for the tree leaf distance matrix block.
// Holds the controller state type and the command/status structs; no dependencies.
`default_nettype none
package tldm_pkg;
    localparam int NBR = 3;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CLEAR,
        S_FIND,
        S_WALK,
        S_ECC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic find;
        logic walk;
        logic ecc;
        logic emit;
        logic next_leaf;
        logic reset_fill;
    } t_cmd;

    typedef struct packed {
        logic find_done;
        logic found;
        logic walk_done;
        logic leaf_last;
        logic emit_last;
    } t_status;
endpackage
`default_nettype wire

/* hw/rtl/tree_leaf_distance_matrix.sv */
// Leaf distance matrix of an unrooted binary tree, loaded one edge per transaction.
// Flow: edges are taken back to back while loading; after the last edge a clear step,
// then for each leaf a search of the internal nodes for its father, a bounded walk
// and an eccentricity write (a leaf no internal node lists skips the walk); the
// LEAVES*LEAVES entries then leave one at a time through the output register.
// Reset (synchronous, active low) empties the adjacency lists and the controller.
`default_nettype none
module tree_leaf_distance_matrix #(
    parameter int LEAVES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // end_a[3:0], end_b[7:4]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // row_leaf, col_leaf, hops, row_eccentricity, diameter
    output logic             m_axis_tlast
);
    tldm_pkg::t_cmd    cmd;
    tldm_pkg::t_status status;
    logic in_fire, out_load, out_final;
    logic [3:0] row, col;
    logic [2:0] hops, ecc, diam;
    logic r_valid;
    logic [16:0] r_data;
    logic r_last;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    tldm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire), .i_last(s_axis_tlast),
        .i_out_free(!r_valid || m_axis_tready), .i_status(status), .o_cmd(cmd),
        .o_in_ready(s_axis_tready), .o_out_load(out_load), .o_out_final(out_final)
    );

    tldm_datapath #(.LEAVES(LEAVES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_end_a(s_axis_tdata[3:0]), .i_end_b(s_axis_tdata[7:4]), .o_status(status),
        .o_row(row), .o_col(col), .o_hops(hops), .o_ecc(ecc), .o_diam(diam)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (out_load) r_valid <= 1'b1;
        else if (m_axis_tready) r_valid <= 1'b0;
        if (out_load) begin
            r_data <= {diam, ecc, hops, col, row};
            r_last <= out_final;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_data};
    assign m_axis_tlast  = r_last;

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!$past(r_valid) || $past(m_axis_tready)))
        else $error("output register overwritten");
    a_no_input_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken during emit");
    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tlast) |=> !s_axis_tready)
        else $error("ready after last edge");
endmodule
`default_nettype wire

/* hw/rtl/tldm_datapath.sv */
// Datapath: adjacency table, walk stacks, distance memory, emit counters.
// Depends on tldm_pkg.
`default_nettype none
module tldm_datapath #(
    parameter int LEAVES = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tldm_pkg::t_cmd    i_cmd,
    input  wire logic [3:0]        i_end_a,
    input  wire logic [3:0]        i_end_b,
    output tldm_pkg::t_status      o_status,
    output logic [3:0]             o_row,
    output logic [3:0]             o_col,
    output logic [2:0]             o_hops,
    output logic [2:0]             o_ecc,
    output logic [2:0]             o_diam
);
    localparam int INNER = LEAVES - 2;
    localparam int NODE_MAX = 2 * LEAVES - 2;
    localparam int LW = $clog2(LEAVES);
    localparam int SW = $clog2(INNER);
    localparam int AW = 2 * LW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int WALK_LIMIT = 8 * LEAVES;
    localparam int CW = $clog2(WALK_LIMIT + 1);

    logic [3:0] r_nbr [INNER][tldm_pkg::NBR];
    logic [1:0] r_fill [INNER];
    logic [2:0] r_depth [INNER];
    logic [3:0] r_par [INNER];
    logic [1:0] r_cur [INNER];
    logic [2:0] r_dist [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_dvalid;
    logic [2:0] r_eccm [LEAVES];

    logic [LW-1:0] r_leaf;     // walk source leaf minus one
    logic [SW:0]   r_scan;     // father search index
    logic [3:0]    r_node;     // current node
    logic [3:0]    r_father;
    logic [CW-1:0] r_steps;
    logic [2:0]    r_ecc_acc;
    logic [2:0]    r_diam;
    logic [LW-1:0] r_erow;
    logic [LW-1:0] r_ecol;
    logic [LW-1:0] r_erow_q;
    logic [LW-1:0] r_ecol_q;
    logic [2:0]    r_rd;
    logic          r_rd_v;
    logic [2:0]    r_rd_ecc;
    logic          r_walk_done;

    function automatic logic is_inner(input logic [3:0] v);
        return ({1'b0, v} > 5'(LEAVES)) && ({1'b0, v} <= 5'(NODE_MAX));
    endfunction
    function automatic logic [2:0] sat_inc(input logic [2:0] v);
        return (v == 3'd7) ? 3'd7 : v + 3'd1;
    endfunction
    function automatic logic [SW-1:0] slot(input logic [3:0] v);
        logic [3:0] t;
        t = v - 4'(LEAVES + 1);
        return t[SW-1:0];
    endfunction

    logic [3:0] leaf_id;
    assign leaf_id = 4'({1'b0, r_leaf}) + 4'd1;

    // Father search: one internal node per cycle, lowest first.
    logic scan_hit;
    always_comb begin
        scan_hit = 1'b0;
        if (r_scan < (SW+1)'(INNER)) begin
            for (int k = 0; k < tldm_pkg::NBR; k++) begin
                if (2'(k) < r_fill[r_scan[SW-1:0]] &&
                        r_nbr[r_scan[SW-1:0]][k] == leaf_id)
                    scan_hit = 1'b1;
            end
        end
    end

    logic [SW-1:0] cs;
    logic [3:0]    v_nb;
    logic          has_nb;
    assign cs     = slot(r_node);
    assign has_nb = r_cur[cs] < r_fill[cs];
    assign v_nb   = r_nbr[cs][r_cur[cs]];

    logic [2:0] h_new;
    assign h_new = sat_inc(r_depth[cs]);
    logic leaf_hit;
    assign leaf_hit = i_cmd.walk && !r_walk_done && has_nb && v_nb != r_par[cs] &&
                      !is_inner(v_nb) && v_nb >= 4'd1 && {1'b0, v_nb} <= 5'(LEAVES) &&
                      v_nb != leaf_id;

    logic [LW-1:0] vl;
    assign vl = LW'(v_nb - 4'd1);

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    assign wr_addr = {r_leaf, vl};
    assign rd_addr = {r_erow, r_ecol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < INNER; s++) r_fill[s] <= '0;
            r_walk_done <= 1'b0;
            r_diam <= '0;
        end else begin
            if (i_cmd.load) begin
                if (is_inner(i_end_a) && r_fill[slot(i_end_a)] != 2'd3) begin
                    r_nbr[slot(i_end_a)][r_fill[slot(i_end_a)]] <= i_end_b;
                    r_fill[slot(i_end_a)] <= r_fill[slot(i_end_a)] + 2'd1;
                end
                if (is_inner(i_end_b)) begin
                    if (is_inner(i_end_a) && i_end_a == i_end_b) begin
                        if (r_fill[slot(i_end_b)] < 2'd2) begin
                            r_nbr[slot(i_end_b)][r_fill[slot(i_end_b)] + 2'd1] <= i_end_a;
                            r_fill[slot(i_end_b)] <= r_fill[slot(i_end_b)] + 2'd2;
                        end
                    end else if (r_fill[slot(i_end_b)] != 2'd3) begin
                        r_nbr[slot(i_end_b)][r_fill[slot(i_end_b)]] <= i_end_a;
                        r_fill[slot(i_end_b)] <= r_fill[slot(i_end_b)] + 2'd1;
                    end
                end
            end
            if (i_cmd.clear) begin
                r_diam <= '0;
                r_leaf <= '0;
                r_scan <= '0;
            end
            if (i_cmd.find) begin
                r_ecc_acc <= '0;
                r_steps <= '0;
                r_walk_done <= 1'b0;
                if (scan_hit) begin
                    r_father <= 4'(r_scan) + 4'(LEAVES + 1);
                    r_node <= 4'(r_scan) + 4'(LEAVES + 1);
                    r_depth[r_scan[SW-1:0]] <= 3'd1;
                    r_par[r_scan[SW-1:0]] <= leaf_id;
                    r_cur[r_scan[SW-1:0]] <= '0;
                end else begin
                    r_scan <= r_scan + 1'b1;
                end
            end
            if (i_cmd.walk && !r_walk_done) begin
                r_steps <= r_steps + 1'b1;
                if (r_steps == CW'(WALK_LIMIT - 1)) r_walk_done <= 1'b1;
                if (has_nb) begin
                    r_cur[cs] <= r_cur[cs] + 2'd1;
                    if (v_nb != r_par[cs] && is_inner(v_nb)) begin
                        r_depth[slot(v_nb)] <= h_new;
                        r_par[slot(v_nb)] <= r_node;
                        r_cur[slot(v_nb)] <= '0;
                        r_node <= v_nb;
                    end
                end else if (r_node == r_father || !is_inner(r_par[cs])) begin
                    r_walk_done <= 1'b1;
                end else begin
                    r_node <= r_par[cs];
                end
            end
            if (leaf_hit) begin
                if (h_new > r_ecc_acc) r_ecc_acc <= h_new;
                if (h_new > r_diam) r_diam <= h_new;
            end
            if (i_cmd.ecc) begin
                r_eccm[r_leaf] <= i_cmd.find ? 3'd0 : r_ecc_acc;
            end
            if (i_cmd.next_leaf) begin
                r_leaf <= r_leaf + 1'b1;
                r_scan <= '0;
            end
            if (i_cmd.reset_fill) begin
                for (int s = 0; s < INNER; s++) r_fill[s] <= '0;
            end
        end
    end

    // Distance memory, written by the walk and read at the emit address for each emitted entry.
    always_ff @(posedge i_clk) begin
        if (leaf_hit) r_dist[wr_addr] <= h_new;
        r_rd <= r_dist[rd_addr];
    end

    // One valid bit per entry, so that entries no walk reached read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) r_dvalid <= '0;
        else if (leaf_hit) r_dvalid[wr_addr] <= 1'b1;
        r_rd_v <= r_dvalid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_erow <= '0;
            r_ecol <= '0;
        end else if (i_cmd.emit) begin
            if (r_ecol == LW'(LEAVES - 1)) begin
                r_ecol <= '0;
                r_erow <= r_erow + 1'b1;
            end else begin
                r_ecol <= r_ecol + 1'b1;
            end
        end
        r_rd_ecc <= r_eccm[r_erow];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_erow_q <= r_erow;
            r_ecol_q <= r_ecol;
        end
    end

    assign o_row  = 4'(r_erow_q) + 4'd1;
    assign o_col  = 4'(r_ecol_q) + 4'd1;
    assign o_hops = (r_erow_q == r_ecol_q) ? 3'd0 : (r_rd_v ? r_rd : 3'd0);
    assign o_ecc  = r_rd_ecc;
    assign o_diam = r_diam;

    assign o_status.find_done  = scan_hit || r_scan >= (SW+1)'(INNER);
    assign o_status.found      = scan_hit;
    assign o_status.walk_done  = r_walk_done;
    assign o_status.leaf_last  = r_leaf == LW'(LEAVES - 1);
    assign o_status.emit_last  = (r_erow == LW'(LEAVES - 1)) && (r_ecol == LW'(LEAVES - 1));
endmodule
`default_nettype wire

/* hw/rtl/tldm_ctrl.sv */
// Controller state machine for the distance matrix block.
// Depends on tldm_pkg; drives tldm_datapath by command struct.
`default_nettype none
module tldm_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_fire,
    input  wire logic               i_last,
    input  wire logic               i_out_free,
    input  wire tldm_pkg::t_status  i_status,
    output tldm_pkg::t_cmd          o_cmd,
    output logic                    o_in_ready,
    output logic                    o_out_load,
    output logic                    o_out_final
);
    tldm_pkg::t_state r_state, n_state;
    logic r_pend, r_pend_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tldm_pkg::S_LOAD;
            r_pend <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state <= n_state;
            // Data returns in the cycle after each emit read.
            r_pend <= o_cmd.emit;
            r_pend_last <= o_cmd.emit && i_status.emit_last;
        end
    end

    assign o_out_load  = r_pend;
    assign o_out_final = r_pend_last;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tldm_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
                if (i_in_fire && i_last) n_state = tldm_pkg::S_CLEAR;
            end
            tldm_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state = tldm_pkg::S_FIND;
            end
            tldm_pkg::S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_status.found) n_state = tldm_pkg::S_WALK;
                else if (i_status.find_done) begin
                    o_cmd.ecc = 1'b1;
                    o_cmd.next_leaf = 1'b1;
                    if (i_status.leaf_last) n_state = tldm_pkg::S_EMIT;
                end
            end
            tldm_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) n_state = tldm_pkg::S_ECC;
            end
            tldm_pkg::S_ECC: begin
                o_cmd.ecc = 1'b1;
                o_cmd.next_leaf = 1'b1;
                n_state = i_status.leaf_last ? tldm_pkg::S_EMIT : tldm_pkg::S_FIND;
            end
            tldm_pkg::S_EMIT: begin
                if (i_out_free && !r_pend) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.reset_fill = 1'b1;
                        n_state = tldm_pkg::S_LOAD;
                    end
                end
            end
            default: n_state = tldm_pkg::S_LOAD;
        endcase
    end
endmodule
`default_nettype wire
